>>> hdl/lfcd_pkg.sv
// Shared types and constants of the FIFO/LRU cache directory.
// No dependencies; every other file of the block uses this package.
package lfcd_pkg;

	// Field widths of requests, results and registers
	localparam int KEY_W     = 64;
	localparam int PORT_W    = 16;
	localparam int STAMP_W   = 64;
	localparam int SLOT_W    = 10;
	localparam int POL_W     = 2;
	localparam int CAP_W     = 11;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POLICY   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'b1;

	// Replacement policies
	localparam logic [POL_W-1:0] POL_NONE = 2'd0;
	localparam logic [POL_W-1:0] POL_FIFO = 2'd1;
	localparam logic [POL_W-1:0] POL_LRU  = 2'd2;

	// Request opcodes
	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	// One directory entry as held in the slot memories
	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [PORT_W-1:0]  port;
		logic [STAMP_W-1:0] ins_stamp;
		logic [STAMP_W-1:0] use_stamp;
	} entry_t;

	// Write enables toward the slot memories
	typedef struct packed {
		logic valid_we;
		logic valid_bit;
		logic entry_we;
		logic use_we;
	} wr_cmd_t;

	// One response item
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              stored;
		logic              evicted;
		logic [SLOT_W-1:0] evicted_slot;
	} result_t;

endpackage

>>> hdl/lfcd_if.sv
// Request and response channel interfaces of the cache directory.
// Depends on lfcd_pkg for the field widths.
interface lfcd_req_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [lfcd_pkg::KEY_W-1:0]  key_tag;
	logic [lfcd_pkg::PORT_W-1:0] port;

	modport source (output valid, op, key_tag, port, input ready);
	modport sink (input valid, op, key_tag, port, output ready);
endinterface

interface lfcd_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        hit;
	logic [lfcd_pkg::SLOT_W-1:0] slot;
	logic                        stored;
	logic                        evicted;
	logic [lfcd_pkg::SLOT_W-1:0] evicted_slot;

	modport source (output valid, hit, slot, stored, evicted, evicted_slot, input ready);
	modport sink (input valid, hit, slot, stored, evicted, evicted_slot, output ready);
endinterface

>>> hdl/fifo_lru_cache_directory.sv
// Fully associative cache directory with FIFO or LRU replacement.
// While caching is on, each request scans every slot through one registered memory read
// port and one 64-bit stamp comparator, then drains, finishes and responds; when caching
// is off it goes straight to the response. One request at a time, no overlap.
// Reset (arst_n low, asynchronous) clears control state, then a clearing pass over every
// slot zeroes the valid bits; no request is taken until it ends.
module fifo_lru_cache_directory #(
	parameter int ENTRIES = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lfcd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lfcd_pkg::CFG_W-1:0]         cfg_data,
	lfcd_req_if.sink                           req,
	lfcd_rsp_if.source                         rsp
);
	import lfcd_pkg::*;

	localparam int AW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int UCW   = $clog2(ENTRIES + 1);
	localparam int CNT_W = (UCW > CAP_W) ? UCW : CAP_W;
	localparam int XW    = (AW > SLOT_W) ? AW : SLOT_W;
	localparam logic [AW-1:0]    LAST_IDX = AW'(ENTRIES - 1);
	localparam logic [CNT_W-1:0] ENT_CNT  = CNT_W'(ENTRIES);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic [AW-1:0]      iss_q;
	logic               cmp_vld_s1;
	logic [AW-1:0]      idx_s1;
	logic               op_q;
	logic [KEY_W-1:0]   key_q;
	logic [PORT_W-1:0]  port_q;
	logic               found_q;
	logic [AW-1:0]      best_idx_q;
	logic [STAMP_W-1:0] best_stamp_q;
	logic               free_have_q;
	logic [AW-1:0]      free_idx_q;
	logic [UCW-1:0]     used_q;
	logic [STAMP_W-1:0] tick_q;
	logic [POL_W-1:0]   policy_q;
	logic [CAP_W-1:0]   capacity_q;
	result_t            res_q;
	logic               out_vld_q;
	result_t            out_q;

	entry_t             rd_data;
	entry_t             wr_data;
	wr_cmd_t            wr_cmd;
	logic [AW-1:0]      wr_addr;

	logic [CNT_W-1:0]   cap_ext;
	logic [CNT_W-1:0]   cap_eff;
	logic               cache_on;
	logic               full;
	logic               key_match;
	logic [STAMP_W-1:0] stamp_rd;
	logic [STAMP_W-1:0] cmp_a;
	logic [STAMP_W-1:0] cmp_b;
	logic               cmp_lt;
	logic               take;
	logic               free_take;
	logic               do_evict;
	logic               do_store;
	logic               lru_touch;
	logic [AW-1:0]      target;
	result_t            fin_res;

	function automatic logic [SLOT_W-1:0] to_slot(input logic [AW-1:0] idx);
		logic [XW-1:0] w;
		w = XW'(idx);
		return w[SLOT_W-1:0];
	endfunction

	lfcd_store #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_store (
		.clk     (clk),
		.rd_addr (iss_q),
		.rd_data (rd_data),
		.wr_cmd  (wr_cmd),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Clamp capacity to the directory size; caching needs a real policy and a nonzero capacity
	assign cap_ext  = CNT_W'(capacity_q);
	assign cap_eff  = (cap_ext > ENT_CNT) ? ENT_CNT : cap_ext;
	assign cache_on = ((policy_q == POL_FIFO) || (policy_q == POL_LRU)) && (cap_eff != '0);
	assign full     = CNT_W'(used_q) >= cap_eff;

	// Shared stamp comparator: newest insertion on lookup, oldest stamp on insert
	assign key_match = rd_data.valid && (rd_data.key == key_q) && (rd_data.port == port_q);
	assign stamp_rd  = ((op_q == OP_LOOKUP) || (policy_q == POL_FIFO)) ?
	                   rd_data.ins_stamp : rd_data.use_stamp;
	assign cmp_a     = (op_q == OP_LOOKUP) ? best_stamp_q : stamp_rd;
	assign cmp_b     = (op_q == OP_LOOKUP) ? stamp_rd : best_stamp_q;
	assign cmp_lt    = cmp_a < cmp_b;
	assign take      = cmp_vld_s1 && ((op_q == OP_LOOKUP) ? key_match : rd_data.valid) &&
	                   (!found_q || cmp_lt);
	assign free_take = cmp_vld_s1 && !rd_data.valid && !free_have_q;

	// Decide the outcome once the scan has finished
	assign do_evict  = (op_q == OP_INSERT) && full && found_q;
	assign do_store  = (op_q == OP_INSERT) && (do_evict || free_have_q);
	assign lru_touch = (op_q == OP_LOOKUP) && found_q && (policy_q == POL_LRU);
	assign target    = do_evict ? best_idx_q : free_idx_q;

	always_comb begin
		fin_res              = '0;
		fin_res.hit          = (op_q == OP_LOOKUP) && found_q;
		fin_res.stored       = do_store;
		fin_res.evicted      = do_evict;
		fin_res.evicted_slot = do_evict ? to_slot(best_idx_q) : '0;
		if (fin_res.hit) begin
			fin_res.slot = to_slot(best_idx_q);
		end else if (do_store) begin
			fin_res.slot = to_slot(target);
		end
	end

	// Drive the memory write port: clearing pass or the final update
	always_comb begin
		wr_cmd            = '0;
		wr_addr           = target;
		wr_data.valid     = 1'b1;
		wr_data.key       = key_q;
		wr_data.port      = port_q;
		wr_data.ins_stamp = tick_q;
		wr_data.use_stamp = tick_q;
		case (state_q)
			ST_CLEAR: begin
				wr_cmd.valid_we  = 1'b1;
				wr_cmd.valid_bit = 1'b0;
				wr_addr          = iss_q;
			end
			ST_FIN: begin
				if (do_store) begin
					wr_cmd.valid_we  = 1'b1;
					wr_cmd.valid_bit = 1'b1;
					wr_cmd.entry_we  = 1'b1;
					wr_cmd.use_we    = 1'b1;
				end else if (lru_touch) begin
					wr_cmd.use_we = 1'b1;
					wr_addr       = best_idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer, scan trackers, configuration and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			iss_q        <= '0;
			cmp_vld_s1   <= 1'b0;
			idx_s1       <= '0;
			op_q         <= OP_LOOKUP;
			key_q        <= '0;
			port_q       <= '0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_stamp_q <= '0;
			free_have_q  <= 1'b0;
			free_idx_q   <= '0;
			used_q       <= '0;
			tick_q       <= '0;
			policy_q     <= POL_NONE;
			capacity_q   <= '0;
			res_q        <= '0;
			out_vld_q    <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POLICY:   policy_q   <= cfg_data[POL_W-1:0];
					REG_CAPACITY: capacity_q <= cfg_data[CAP_W-1:0];
					default: begin
					end
				endcase
			end

			// Drop the response once taken; in ST_OUT the reload below decides
			if (out_vld_q && rsp.ready && (state_q != ST_OUT)) begin
				out_vld_q <= 1'b0;
			end

			// Advance the read pipeline and track the best and the first free slot
			cmp_vld_s1 <= (state_q == ST_SCAN);
			idx_s1     <= iss_q;
			if (take) begin
				found_q      <= 1'b1;
				best_idx_q   <= idx_s1;
				best_stamp_q <= stamp_rd;
			end
			if (free_take) begin
				free_have_q <= 1'b1;
				free_idx_q  <= idx_s1;
			end

			case (state_q)
				ST_CLEAR: begin
					iss_q <= iss_q + AW'(1);
					if (iss_q == LAST_IDX) begin
						iss_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req.valid) begin
						op_q        <= req.op;
						key_q       <= req.key_tag;
						port_q      <= req.port;
						found_q     <= 1'b0;
						free_have_q <= 1'b0;
						iss_q       <= '0;
						if (cache_on) begin
							state_q <= ST_SCAN;
						end else begin
							res_q   <= '0;
							state_q <= ST_OUT;
						end
					end
				end
				ST_SCAN: begin
					iss_q <= iss_q + AW'(1);
					if (iss_q == LAST_IDX) begin
						iss_q   <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					res_q <= fin_res;
					if (do_store) begin
						tick_q <= tick_q + STAMP_W'(1);
						if (!do_evict) begin
							used_q <= used_q + UCW'(1);
						end
					end else if (lru_touch) begin
						tick_q <= tick_q + STAMP_W'(1);
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_vld_q || rsp.ready) begin
						out_q     <= res_q;
						out_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready        = (state_q == ST_IDLE);
	assign rsp.valid        = out_vld_q;
	assign rsp.hit          = out_q.hit;
	assign rsp.slot         = out_q.slot;
	assign rsp.stored       = out_q.stored;
	assign rsp.evicted      = out_q.evicted;
	assign rsp.evicted_slot = out_q.evicted_slot;

`ifndef NO_ASSERTIONS
	a_evict_implies_store: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.evicted |-> rsp.stored)
		else $error("eviction reported without a store");

	a_hit_or_store: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.stored))
		else $error("response shows both hit and stored");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UCW'(ENTRIES))
		else $error("used count exceeds directory size");

	a_tick_step: assert property (@(posedge clk) disable iff (!arst_n)
		(tick_q != $past(tick_q)) |-> (tick_q == $past(tick_q) + STAMP_W'(1)))
		else $error("tick moved by more than one");
`endif

endmodule

>>> hdl/lfcd_store.sv
// Slot memories of the cache directory: valid, key, port and both stamps.
// One write address and one read address with registered data per cycle; uses lfcd_pkg.
module lfcd_store #(
	parameter int ENTRIES = 1024,
	parameter int AW      = 10
) (
	input  logic               clk,
	input  logic [AW-1:0]      rd_addr,
	output lfcd_pkg::entry_t   rd_data,
	input  lfcd_pkg::wr_cmd_t  wr_cmd,
	input  logic [AW-1:0]      wr_addr,
	input  lfcd_pkg::entry_t   wr_data
);
	import lfcd_pkg::*;

	logic               valid_mem [ENTRIES];
	logic [KEY_W-1:0]   key_mem   [ENTRIES];
	logic [PORT_W-1:0]  port_mem  [ENTRIES];
	logic [STAMP_W-1:0] ins_mem   [ENTRIES];
	logic [STAMP_W-1:0] use_mem   [ENTRIES];

	// Write the selected fields of one slot
	always_ff @(posedge clk) begin
		if (wr_cmd.valid_we) begin
			valid_mem[wr_addr] <= wr_cmd.valid_bit;
		end
		if (wr_cmd.entry_we) begin
			key_mem[wr_addr]  <= wr_data.key;
			port_mem[wr_addr] <= wr_data.port;
			ins_mem[wr_addr]  <= wr_data.ins_stamp;
		end
		if (wr_cmd.use_we) begin
			use_mem[wr_addr] <= wr_data.use_stamp;
		end
	end

	// Read one slot, data registered
	always_ff @(posedge clk) begin
		rd_data.valid     <= valid_mem[rd_addr];
		rd_data.key       <= key_mem[rd_addr];
		rd_data.port      <= port_mem[rd_addr];
		rd_data.ins_stamp <= ins_mem[rd_addr];
		rd_data.use_stamp <= use_mem[rd_addr];
	end

endmodule
